// File: sv/mfbp_pkg.sv
// mfbp_pkg: shared constants and types of the msb-first bit packer
// no dependencies
`default_nettype none

package mfbp_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 6;
   localparam int BYTE_W      = 8;
   localparam int MAX_BITS    = 32;
   // a count is limited to MAX_BITS and to the width of value
   localparam int EFF_MAX     = (MAX_BITS < VALUE_W) ? MAX_BITS : VALUE_W;
   localparam int PEND_W      = BYTE_W - 1;
   localparam int REM_W       = $clog2(BYTE_W);
   localparam int WORD_W      = PEND_W + VALUE_W;
   localparam int TOTAL_W     = $clog2(WORD_W + 1);
   localparam int MAX_BYTES   = (PEND_W + EFF_MAX) / BYTE_W;
   localparam int NBYTES_W    = $clog2(MAX_BYTES + 1);
   localparam int SHIFT_W     = $clog2(WORD_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            full;
      logic            head_valid;
      queue_entry_type head;
   } queue_status_type;

endpackage

`default_nettype wire

// File: sv/mfbp_req_if.sv
// mfbp_req_if: input channel of the bit packer, value and bit count
// depends on mfbp_pkg
`default_nettype none

interface mfbp_req_if;
   logic                           valid;
   logic                           ready;
   logic [mfbp_pkg::VALUE_W-1:0]   value;
   logic [mfbp_pkg::COUNT_W-1:0]   bit_count;

   modport source (output valid, output value, output bit_count, input ready);
   modport sink   (input valid, input value, input bit_count, output ready);
endinterface

`default_nettype wire

// File: sv/mfbp_rsp_if.sv
// mfbp_rsp_if: result channel of the bit packer, packed byte and last mark
// depends on mfbp_pkg
`default_nettype none

interface mfbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mfbp_pkg::BYTE_W-1:0]   byte_out;
   logic                          last;

   modport source (output valid, output byte_out, output last, input ready);
   modport sink   (input valid, input byte_out, input last, output ready);
endinterface

`default_nettype wire

// File: sv/msb_first_bit_packer.sv
// msb_first_bit_packer: top level of the msb-first bitstream writer
// depends on mfbp_pkg, mfbp_req_if, mfbp_rsp_if, mfbp_front, mfbp_queue, mfbp_back
`default_nettype none

// Each req item appends the low bit_count bits of value (counts above 32
// saturate to 32), most significant first, to a pending partial byte; every
// completed byte leaves on rsp with the earliest bit in bit 7, and the final
// byte caused by an item carries last. Leftover bits stay pending, there is
// no flush, and an item that completes no byte gives no rsp item. The front
// saturates the count, drops empty items and pushes the rest into a two-entry
// queue; the back takes a queued item only once every byte of the last item
// has entered its output register, merges it with the pending bits, then sends
// one byte per cycle through its output register while rsp is ready. The queue
// lets req keep being taken while rsp is stalled, until the queue fills.

module msb_first_bit_packer (
   input  logic        clock,
   input  logic        reset,
   mfbp_req_if.sink    req,
   mfbp_rsp_if.source  rsp
);

   mfbp_pkg::queue_push_type   q_push;
   mfbp_pkg::queue_status_type q_status;
   logic                       pop;

   // accept, saturate the count, filter items with nothing to append
   mfbp_front u_front (
      .req      (req),
      .q_status (q_status),
      .q_push   (q_push)
   );

   // short queue parting the two sides
   mfbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .q_status (q_status)
   );

   // merge with pending bits and emit completed bytes
   mfbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// File: sv/mfbp_front.sv
// mfbp_front: accepts items, saturates the bit count, drops empty items
// depends on mfbp_pkg and mfbp_req_if
`default_nettype none

module mfbp_front (
   mfbp_req_if.sink                  req,
   input  mfbp_pkg::queue_status_type q_status,
   output mfbp_pkg::queue_push_type   q_push
);

   logic [mfbp_pkg::COUNT_W-1:0] eff_count;

   always_comb begin
      if (req.bit_count > mfbp_pkg::COUNT_W'(mfbp_pkg::EFF_MAX)) begin
         eff_count = mfbp_pkg::COUNT_W'(mfbp_pkg::EFF_MAX);
      end else begin
         eff_count = req.bit_count;
      end
   end

   assign req.ready = !q_status.full;

   // a zero count changes nothing, so it never enters the queue
   assign q_push.valid       = req.valid && !q_status.full && (eff_count != '0);
   assign q_push.entry.value = req.value;
   assign q_push.entry.count = eff_count;

endmodule

`default_nettype wire

// File: sv/mfbp_queue.sv
// mfbp_queue: short fifo between front and back of the bit packer
// depends on mfbp_pkg
`default_nettype none

module mfbp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  mfbp_pkg::queue_push_type   q_push,
   input  logic                       pop,
   output mfbp_pkg::queue_status_type q_status
);

   mfbp_pkg::queue_entry_type         slot_ff [mfbp_pkg::QUEUE_DEPTH];
   logic [mfbp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mfbp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mfbp_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   function automatic logic [mfbp_pkg::QPTR_W-1:0] ptr_next(
      input logic [mfbp_pkg::QPTR_W-1:0] p);
      if (p == mfbp_pkg::QPTR_W'(mfbp_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign q_status.full       = (cnt_ff == mfbp_pkg::QCNT_W'(mfbp_pkg::QUEUE_DEPTH));
   assign q_status.head_valid = (cnt_ff != '0);
   assign q_status.head       = slot_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_status.full;
   assign do_pop  = pop && q_status.head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

`default_nettype wire

// File: sv/mfbp_back.sv
// mfbp_back: merges queued bits with the pending partial byte, emits bytes
// depends on mfbp_pkg and mfbp_rsp_if
`default_nettype none

module mfbp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mfbp_pkg::queue_status_type q_status,
   output logic                       pop,
   mfbp_rsp_if.source                 rsp
);

   localparam int WORD_W = mfbp_pkg::WORD_W;

   logic [WORD_W-1:0]               word_ff, word_in;
   logic [mfbp_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [mfbp_pkg::NBYTES_W-1:0]   nbytes_ff, nbytes_in;
   logic [mfbp_pkg::PEND_W-1:0]     pend_bits_ff, pend_bits_in;
   logic [mfbp_pkg::REM_W-1:0]      pend_cnt_ff, pend_cnt_in;
   logic                            out_valid_ff, out_valid_in;
   logic [mfbp_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic                            last_ff, last_in;

   logic [mfbp_pkg::VALUE_W:0]      value_mask;
   logic [WORD_W-1:0]               merged;
   logic [mfbp_pkg::TOTAL_W-1:0]    total;
   logic [mfbp_pkg::BYTE_W-1:0]     rem_mask;
   logic [mfbp_pkg::TOTAL_W-1:0]    shift_wide;
   logic [mfbp_pkg::SHIFT_W-1:0]    shift;
   logic [mfbp_pkg::NBYTES_W-1:0]   nbytes_dec;
   logic                            out_free;

   assign pop      = (nbytes_ff == '0);
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      value_mask = ((mfbp_pkg::VALUE_W+1)'(1) << q_status.head.count) - 1'b1;
      merged     = ((WORD_W'(pend_bits_ff)) << q_status.head.count)
                 | WORD_W'(q_status.head.value & value_mask[mfbp_pkg::VALUE_W-1:0]);
      total      = mfbp_pkg::TOTAL_W'(pend_cnt_ff) + mfbp_pkg::TOTAL_W'(q_status.head.count);
      rem_mask   = (mfbp_pkg::BYTE_W'(1) << total[mfbp_pkg::REM_W-1:0]) - 1'b1;
      nbytes_dec = nbytes_ff - 1'b1;
      shift_wide = mfbp_pkg::TOTAL_W'(rem_ff)
                 + (mfbp_pkg::TOTAL_W'(nbytes_dec) << mfbp_pkg::REM_W);
      shift      = shift_wide[mfbp_pkg::SHIFT_W-1:0];

      word_in      = word_ff;
      rem_in       = rem_ff;
      nbytes_in    = nbytes_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;

      if (pop && q_status.head_valid) begin
         word_in      = merged;
         rem_in       = total[mfbp_pkg::REM_W-1:0];
         nbytes_in    = total[mfbp_pkg::REM_W +: mfbp_pkg::NBYTES_W];
         pend_bits_in = merged[mfbp_pkg::PEND_W-1:0] & rem_mask[mfbp_pkg::PEND_W-1:0];
         pend_cnt_in  = total[mfbp_pkg::REM_W-1:0];
      end

      if (nbytes_ff != '0 && out_free) begin
         byte_in      = mfbp_pkg::BYTE_W'(word_ff >> shift);
         last_in      = (nbytes_ff == mfbp_pkg::NBYTES_W'(1));
         out_valid_in = 1'b1;
         nbytes_in    = nbytes_dec;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nbytes_ff    <= '0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         nbytes_ff    <= nbytes_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rem_ff  <= rem_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.byte_out = byte_ff;
   assign rsp.last     = last_ff;

   a_nbytes_bound: assert property (@(posedge clock) disable iff (reset)
      nbytes_ff <= mfbp_pkg::NBYTES_W'(mfbp_pkg::MAX_BYTES))
      else $error("byte count above the most one item can give");

   a_final_byte_marked: assert property (@(posedge clock) disable iff (reset)
      (nbytes_ff == mfbp_pkg::NBYTES_W'(1) && out_free) |=> (out_valid_ff && last_ff))
      else $error("final byte of an item not marked last");

   a_inner_byte_unmarked: assert property (@(posedge clock) disable iff (reset)
      (nbytes_ff > mfbp_pkg::NBYTES_W'(1) && out_free) |=> (out_valid_ff && !last_ff))
      else $error("inner byte of an item marked last");

endmodule

`default_nettype wire

// File: dv/msb_first_bit_packer_checker.sv
// mfbp_byte_check: watches the req and rsp channels of the msb-first bit packer,
// predicts the packed bytes of each accepted item and compares them in order
// depends on mfbp_pkg, mfbp_req_if, mfbp_rsp_if

module mfbp_byte_check (
   input  logic   clock,
   input  logic   reset,
   mfbp_req_if    req,
   mfbp_rsp_if    rsp,
   output int     fail_count,
   output int     bytes_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [mfbp_pkg::BYTE_W-1:0] packed_byte;
      logic                        last;
   } byte_entry_type;

   // partial byte still waiting for more bits, newest bit in bit 0
   logic [mfbp_pkg::BYTE_W-2:0] held_bits;
   logic [2:0]                  held_count;
   byte_entry_type              expected_bytes[$];
   byte_entry_type              want;

   initial fail_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   // append the low bits of one item, msb first, and queue every byte it completes
   function automatic void append_bits(input logic [mfbp_pkg::VALUE_W-1:0] value,
                                       input logic [mfbp_pkg::COUNT_W-1:0] bit_count);
      int unsigned     n;
      logic [7:0]      acc;
      int unsigned     cnt;
      byte_entry_type  made[$];
      byte_entry_type  e;
      n = bit_count;
      if (n > mfbp_pkg::MAX_BITS) n = mfbp_pkg::MAX_BITS;
      if (n > mfbp_pkg::VALUE_W) n = mfbp_pkg::VALUE_W;
      acc = {1'b0, held_bits};
      cnt = held_count;
      for (int k = int'(n) - 1; k >= 0; k--) begin
         acc = {acc[6:0], value[k]};
         cnt++;
         if (cnt == mfbp_pkg::BYTE_W) begin
            e.packed_byte = acc;
            e.last = 1'b0;
            made.push_back(e);
            acc = '0;
            cnt = 0;
         end
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) expected_bytes.push_back(made[i]);
      held_bits = acc[6:0];
      held_count = cnt[2:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_bits = '0;
         held_count = '0;
         expected_bytes.delete();
      end else begin
         if (req.valid === 1'b1 && req.ready === 1'b1)
            append_bits(req.value, req.bit_count);
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %h arrived with none expected",
                                         rsp.byte_out));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp.byte_out !== want.packed_byte)
                  report_mismatch($sformatf("byte_out %h, expected %h",
                                            rsp.byte_out, want.packed_byte));
               if (rsp.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b on byte %h",
                                            rsp.last, want.last, want.packed_byte));
            end
         end
      end
      bytes_due <= expected_bytes.size();
   end

endmodule

// File: dv/msb_first_bit_packer_test.sv
// msb_first_bit_packer_test: top of the bit packer testbench, clock, reset,
// item stimulus with random idling on both channels, and the verdict
// depends on mfbp_pkg, mfbp_req_if, mfbp_rsp_if, msb_first_bit_packer, mfbp_byte_check

module msb_first_bit_packer_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   fail_count;
   int   bytes_due;

   // percentage of cycles in which each side holds off
   int   req_idle_pct;
   int   rsp_stall_pct;

   mfbp_req_if req_ch ();
   mfbp_rsp_if rsp_ch ();

   msb_first_bit_packer DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // predicts and compares every byte, hands back failures and bytes still owed
   mfbp_byte_check byte_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fail_count (fail_count),
      .bytes_due  (bytes_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: a fresh stall decision at every falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // offer one item after a random gap and hold it until the block takes it;
   // valid stays high straight into the next item when no gap is drawn
   task automatic push_item(input logic [mfbp_pkg::VALUE_W-1:0] value,
                            input logic [mfbp_pkg::COUNT_W-1:0] bit_count);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.value     <= value;
      req_ch.bit_count <= bit_count;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // stop sending until every predicted byte has left the block
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (bytes_due != 0) @(negedge clock);
   endtask

   // mostly in-range counts, with zero counts, full words and saturating counts
   function automatic logic [mfbp_pkg::COUNT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)  return '0;
      if (r < 18) return mfbp_pkg::COUNT_W'($urandom_range(63, 33));
      if (r < 35) return mfbp_pkg::COUNT_W'(32);
      return mfbp_pkg::COUNT_W'($urandom_range(31, 1));
   endfunction

   task automatic random_items(input int n);
      repeat (n) push_item($urandom, pick_count());
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.value        = '0;
      req_ch.bit_count    = '0;
      req_idle_pct        = 38;
      rsp_stall_pct       = 79;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero count gives no byte
      push_item(32'hFFFF_FFFF, 6'd0);
      // single bits and short runs that only finish a byte across items
      push_item(32'h0000_0001, 6'd1);
      push_item(32'h0000_0000, 6'd1);
      push_item(32'h0000_0005, 6'd3);
      push_item(32'h0000_0003, 6'd2);
      push_item(32'h0000_0001, 6'd1);
      // bits above the count must be ignored
      push_item(32'hFFFF_FFF0, 6'd4);
      push_item(32'h0000_007F, 6'd7);
      push_item(32'h0000_00A5, 6'd8);
      // full words, with the top bit alone, all ones and all zeros
      push_item(32'h8000_0000, 6'd32);
      push_item(32'hFFFF_FFFF, 6'd32);
      push_item(32'h0000_0000, 6'd32);
      // counts past 32 saturate, the largest count included
      push_item(32'h1234_5678, 6'd33);
      push_item(32'hDEAD_BEEF, 6'd63);
      push_item(32'hCAFE_F00D, 6'd40);
      push_item(32'h0000_01FF, 6'd9);
      push_item(32'h7FFF_FFFF, 6'd31);
      push_item(32'h0000_0000, 6'd0);
      push_item(32'h5555_5555, 6'd17);
      push_item(32'hAAAA_AAAA, 6'd32);

      // the sender waits here until every predicted byte has left the block
      hold_until_drained();
      random_items(27);

      req_idle_pct  = 79;
      rsp_stall_pct = 38;
      random_items(27);
      hold_until_drained();

      // no idling on either side: back to back items and bytes
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      random_items(26);

      hold_until_drained();
      // an item that completes no byte may still sit in the block, so let it pass
      // through before judging
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
